// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: field widths, command and status codes,
// controller state encoding and the controller-to-datapath command word.
// No dependencies.
package cdq_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 3;
	localparam int CNT_W         = 5;
	localparam int SLOT_W        = 5;
	localparam int STAT_W        = 2;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [CNT_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [SLOT_W-1:0] SLOT_NONE  = 5'h1F;
	localparam logic              REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY      = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_REAR  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_REAR   = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_SHOW = 2'd2
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // take the input word and update pointer/count/store
		logic rd_en;  // fetch front and rear entries into the read registers
	} ctrl_cmd_t;

endpackage

// ----- rtl/circular_deque.sv -----
// Circular deque top level: APB capacity register, controller and datapath.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp (and cdq_ram below it).
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | command, value
//  output   | out_valid / out_stall| status, is_empty, is_full, count,
//           |                      | front_slot, rear_slot, front_value, rear_value
//  config   | APB psel/penable     | capacity at byte address 0
//
// One word at a time: accept, read front and rear from the registered-read
// ring store, then the result is shown.
// in_stall stays high from acceptance until the result is taken.
// After reset the deque is empty and capacity is 16; no clearing pass.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic                     is_empty,
	output logic                     is_full,
	output logic [CNT_W-1:0]         count,
	output logic signed [SLOT_W-1:0] front_slot,
	output logic signed [SLOT_W-1:0] rear_slot,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value
);

	ctrl_cmd_t        cmd;
	logic             cfg_we;
	logic [CNT_W-1:0] cap;

	// Decode register writes and reads
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap) : '0;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	cdq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_data    (pwdata[CNT_W-1:0]),
		.capacity    (cap),
		.command     (command),
		.value       (value),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.count       (count),
		.front_slot  (front_slot),
		.rear_slot   (rear_slot),
		.front_value (front_value),
		.rear_value  (rear_value)
	);

	// Only one word in flight: no acceptance while a result is shown
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("word accepted while a result is pending");

	// After acceptance the read state comes first, then the result is shown
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##2 out_valid)
		else $error("result did not appear two cycles after acceptance");

	// An empty deque reports no slots and zero values
	a_empty_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (front_slot == SLOT_NONE && rear_slot == SLOT_NONE
			&& front_value == '0 && rear_value == '0 && count == '0))
		else $error("empty result carries slot or value data");

endmodule

// ----- rtl/cdq_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ----- rtl/cdq_ctrl.sv -----
// Controller of the circular deque: sequences load, store read and result.
// Depends on cdq_pkg.
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SHOW;
			end
			S_SHOW: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/cdq_dp.sv -----
// Datapath of the circular deque: capacity register, head pointer, count,
// ring store and result formatting. Depends on cdq_pkg and cdq_ram.
module cdq_dp
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_data,
	output logic [CNT_W-1:0]         capacity,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	output logic [STAT_W-1:0]        status,
	output logic                     is_empty,
	output logic                     is_full,
	output logic [CNT_W-1:0]         count,
	output logic signed [SLOT_W-1:0] front_slot,
	output logic signed [SLOT_W-1:0] rear_slot,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value
);

	localparam int AW = $clog2(DEPTH);
	localparam int W  = ((AW > CNT_W) ? AW : CNT_W) + 1;

	logic [CNT_W-1:0] cap_q;
	logic [AW-1:0]    head_q;
	logic [CNT_W-1:0] count_q;
	status_t          status_q;

	logic [W-1:0] cap_w, head_w, cnt_w, head_n, cnt_n, wslot, rear_w;
	logic         nfull, nempty;
	status_t      status_n;
	logic         we;
	logic [DATA_W-1:0] rd_front, rd_rear;

	// Effective capacity: register clamped to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_w = W'(1);
		end else if (W'(cap_q) > W'(DEPTH)) begin
			cap_w = W'(DEPTH);
		end else begin
			cap_w = W'(cap_q);
		end
	end

	// Next pointer, count and store write for the incoming word
	always_comb begin
		head_w   = (W'(head_q) >= cap_w) ? '0 : W'(head_q);
		cnt_w    = (W'(count_q) > cap_w) ? cap_w : W'(count_q);
		nfull    = (cnt_w == cap_w);
		nempty   = (cnt_w == '0);
		head_n   = head_w;
		cnt_n    = cnt_w;
		status_n = ST_DONE;
		we       = 1'b0;
		wslot    = head_w + cnt_w;
		case (cmd_t'(command))
			CMD_PUSH_FRONT: begin
				if (nfull) begin
					status_n = ST_FULL;
				end else begin
					head_n = (head_w == '0) ? cap_w - W'(1) : head_w - W'(1);
					wslot  = head_n;
					cnt_n  = cnt_w + W'(1);
					we     = 1'b1;
				end
			end
			CMD_PUSH_REAR: begin
				if (nfull) begin
					status_n = ST_FULL;
				end else begin
					if (wslot >= cap_w) begin
						wslot = wslot - cap_w;
					end
					cnt_n = cnt_w + W'(1);
					we    = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (nempty) begin
					status_n = ST_EMPTY;
				end else begin
					head_n = (head_w + W'(1) >= cap_w) ? '0 : head_w + W'(1);
					cnt_n  = cnt_w - W'(1);
				end
			end
			CMD_POP_REAR: begin
				if (nempty) begin
					status_n = ST_EMPTY;
				end else begin
					cnt_n = cnt_w - W'(1);
				end
			end
			default: begin
				status_n = ST_DONE;
			end
		endcase
	end

	// Capacity register; a write empties the deque
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			head_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_data;
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			head_q  <= head_n[AW-1:0];
			count_q <= cnt_n[CNT_W-1:0];
		end
	end

	// Hold the status of the last word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= status_n;
		end
	end

	// Rear slot of the updated deque
	always_comb begin
		rear_w = W'(head_q) + W'(count_q) - W'(1);
		if (rear_w >= cap_w) begin
			rear_w = rear_w - cap_w;
		end
	end

	cdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.load & we),
		.waddr   (wslot[AW-1:0]),
		.wdata   (value),
		.re      (cmd.rd_en),
		.raddr_a (head_q),
		.raddr_b (rear_w[AW-1:0]),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// Format the result word
	always_comb begin
		capacity = cap_q;
		status   = status_q;
		count    = count_q;
		is_empty = (count_q == '0);
		is_full  = (W'(count_q) == cap_w);
		if (count_q == '0) begin
			front_slot  = SLOT_NONE;
			rear_slot   = SLOT_NONE;
			front_value = '0;
			rear_value  = '0;
		end else begin
			front_slot  = SLOT_W'(head_q);
			rear_slot   = rear_w[SLOT_W-1:0];
			front_value = rd_front;
			rear_value  = rd_rear;
		end
	end

endmodule

// ----- tb/sv/cdq_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the circular deque: follows the APB capacity writes and the
// command/result channels, predicts each result word and compares it.
// Depends on cdq_pkg.
module cdq_checker
	import cdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [STAT_W-1:0]        status,
	input  logic                     is_empty,
	input  logic                     is_full,
	input  logic [CNT_W-1:0]         count,
	input  logic signed [SLOT_W-1:0] front_slot,
	input  logic signed [SLOT_W-1:0] rear_slot,
	input  logic signed [DATA_W-1:0] front_value,
	input  logic signed [DATA_W-1:0] rear_value,
	output int                       errors,
	output int                       pending,
	output int                       results,
	output int                       full_rejects,
	output int                       empty_rejects
);

	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);
	localparam int PRINT_LIMIT = 40;

	// What one result word should show
	typedef struct {
		status_t                  st;
		logic                     empty;
		logic                     full;
		logic [CNT_W-1:0]         cnt;
		logic signed [SLOT_W-1:0] fslot;
		logic signed [SLOT_W-1:0] rslot;
		logic signed [DATA_W-1:0] fval;
		logic signed [DATA_W-1:0] rval;
	} deque_view_t;

	// Shadow copy of the deque
	logic [DATA_W-1:0] ring [DEPTH];
	int unsigned       head;
	int unsigned       held;
	logic [CNT_W-1:0]  cap_reg;
	deque_view_t       expected_views[$];

	int err_count;
	int result_count;
	int full_count;
	int empty_count;

	// Register value clamped to 1..DEPTH
	function automatic int unsigned active_slots();
		if (cap_reg == '0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return cap_reg;
	endfunction

	// Apply one command to the shadow deque and return the view after it
	function automatic deque_view_t apply_command(logic [CMD_W-1:0] cmd,
			logic [DATA_W-1:0] val);
		deque_view_t v;
		int unsigned cap;
		int unsigned tail;
		cap = active_slots();
		v.st = ST_DONE;
		if (head >= cap)
			head = 0;
		if (held > cap)
			held = cap;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (held == cap) begin
					v.st = ST_FULL;
				end else begin
					head = (head == 0) ? cap - 1 : head - 1;
					ring[head] = val;
					held++;
				end
			end
			CMD_PUSH_REAR: begin
				if (held == cap) begin
					v.st = ST_FULL;
				end else begin
					tail = head + held;
					if (tail >= cap)
						tail -= cap;
					ring[tail] = val;
					held++;
				end
			end
			CMD_POP_FRONT: begin
				if (held == 0) begin
					v.st = ST_EMPTY;
				end else begin
					head = (head + 1 >= cap) ? 0 : head + 1;
					held--;
				end
			end
			CMD_POP_REAR: begin
				if (held == 0)
					v.st = ST_EMPTY;
				else
					held--;
			end
			// query and unused codes leave the deque alone
			default: ;
		endcase
		v.empty = (held == 0);
		v.full = (held == cap);
		v.cnt = CNT_W'(held);
		if (held == 0) begin
			v.fslot = SLOT_NONE;
			v.rslot = SLOT_NONE;
			v.fval = '0;
			v.rval = '0;
		end else begin
			tail = head + held - 1;
			if (tail >= cap)
				tail -= cap;
			v.fslot = SLOT_W'(head);
			v.rslot = SLOT_W'(tail);
			v.fval = ring[head];
			v.rval = ring[tail];
		end
		return v;
	endfunction

	// Print one error line and count it
	task automatic log_error(input string msg);
		if (err_count < PRINT_LIMIT)
			$display("%0t: result %0d: %s", $time, result_count, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			log_error($sformatf("%s got %h, want %h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ring[i])
				ring[i] = '0;
			head = 0;
			held = 0;
			cap_reg = CAP_RESET;
			expected_views.delete();
			err_count = 0;
			result_count = 0;
			full_count = 0;
			empty_count = 0;
			errors <= 0;
			pending <= 0;
			results <= 0;
			full_rejects <= 0;
			empty_rejects <= 0;
		end else begin
			// compare a taken result word with the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					log_error("result word with no command outstanding");
				end else begin
					deque_view_t want;
					want = expected_views.pop_front();
					check_field("status", 32'(status), 32'(want.st));
					check_field("is_empty", 32'(is_empty), 32'(want.empty));
					check_field("is_full", 32'(is_full), 32'(want.full));
					check_field("count", 32'(count), 32'(want.cnt));
					check_field("front_slot", 32'(front_slot), 32'(want.fslot));
					check_field("rear_slot", 32'(rear_slot), 32'(want.rslot));
					check_field("front_value", front_value, want.fval);
					check_field("rear_value", rear_value, want.rval);
				end
				result_count++;
			end
			// predict for an accepted command word
			if (in_valid && !in_stall) begin
				deque_view_t next_view;
				next_view = apply_command(command, value);
				if (next_view.st == ST_FULL)
					full_count++;
				if (next_view.st == ST_EMPTY)
					empty_count++;
				expected_views.push_back(next_view);
			end
			// capacity write empties the deque, store contents stay
			if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR) begin
				cap_reg = pwdata[CNT_W-1:0];
				head = 0;
				held = 0;
			end
			errors <= err_count;
			pending <= expected_views.size();
			results <= result_count;
			full_rejects <= full_count;
			empty_rejects <= empty_count;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the circular deque testbench: clock, reset, command and capacity
// stimulus, output stall pattern and the verdict. Depends on cdq_pkg,
// circular_deque and cdq_checker.
module tb_top;
	import cdq_pkg::*;

	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int BURST_LEN = 24;

	typedef enum logic [1:0] {
		BURST_FILL,
		BURST_DRAIN,
		BURST_MIX
	} burst_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_W-1:0]       paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         command = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STAT_W-1:0]        status;
	logic                     is_empty;
	logic                     is_full;
	logic [CNT_W-1:0]         count;
	logic signed [SLOT_W-1:0] front_slot;
	logic signed [SLOT_W-1:0] rear_slot;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;

	int errors;
	int pending;
	int results;
	int full_rejects;
	int empty_rejects;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs = 0;
	int holds_started = 0;
	int hold_left = 0;
	int cycles = 0;
	int words_sent = 0;
	int cap_writes = 0;

	always #5 clk = ~clk;

	circular_deque dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.count       (count),
		.front_slot  (front_slot),
		.rear_slot   (rear_slot),
		.front_value (front_value),
		.rear_value  (rear_value)
	);

	cdq_checker deque_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.count         (count),
		.front_slot    (front_slot),
		.rear_slot     (rear_slot),
		.front_value   (front_value),
		.rear_value    (rear_value),
		.errors        (errors),
		.pending       (pending),
		.results       (results),
		.full_rejects  (full_rejects),
		.empty_rejects (empty_rejects)
	);

	// Output side: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != holds_started) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_started <= holds_started + 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped at cycle %0d with %0d results outstanding", cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one command word, idling first at random, and hold it until taken
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
	endtask

	// Drop valid and wait until every result word has been taken
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write of the capacity register: setup then access
	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_writes++;
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
	endtask

	// Bias the command mix so bursts walk the deque toward full or empty
	function automatic logic [CMD_W-1:0] pick_command(burst_t mode);
		int r;
		int pf, pr, qf, qr;
		r = $urandom_range(99);
		case (mode)
			BURST_FILL:  begin pf = 35; pr = 75; qf = 85; qr = 93; end
			BURST_DRAIN: begin pf = 10; pr = 20; qf = 55; qr = 90; end
			default:     begin pf = 22; pr = 44; qf = 66; qr = 88; end
		endcase
		if (r < pf)
			return CMD_PUSH_FRONT;
		if (r < pr)
			return CMD_PUSH_REAR;
		if (r < qf)
			return CMD_POP_FRONT;
		if (r < qr)
			return CMD_POP_REAR;
		if (r < 96)
			return CMD_QUERY;
		return CMD_W'($urandom_range(2**CMD_W - 1, CMD_POP_REAR + 1));
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return {1'b1, {(DATA_W-1){1'b0}}};
			1:       return {1'b0, {(DATA_W-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic run_random(input int n_words);
		burst_t mode;
		mode = BURST_MIX;
		for (int i = 0; i < n_words; i++) begin
			if (i % BURST_LEN == 0)
				mode = burst_t'($urandom_range(BURST_MIX));
			send_word(pick_command(mode), pick_value());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty deque, value extremes, both ends, unused codes
		send_word(CMD_QUERY, '0);
		send_word(CMD_POP_FRONT, '1);
		send_word(CMD_POP_REAR, '1);
		send_word(CMD_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
		send_word(CMD_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
		send_word(CMD_PUSH_FRONT, '1);
		send_word(CMD_PUSH_REAR, '0);
		for (int c = CMD_POP_REAR + 1; c < 2**CMD_W; c++)
			send_word(CMD_W'(c), 32'h1234_5678);
		send_word(CMD_POP_REAR, '0);
		send_word(CMD_POP_FRONT, '0);
		send_word(CMD_POP_FRONT, '0);
		wait_quiet();

		// capacity 0 acts as one slot; the write also empties the deque
		write_capacity('0);
		send_word(CMD_PUSH_REAR, 32'h5A5A_5A5A);
		send_word(CMD_PUSH_FRONT, 32'hA5A5_A5A5);
		send_word(CMD_PUSH_REAR, 32'hA5A5_A5A5);
		send_word(CMD_QUERY, '0);
		send_word(CMD_POP_FRONT, '0);
		send_word(CMD_POP_REAR, '0);
		wait_quiet();

		// oversize register value clamps to full depth
		write_capacity('1);
		set_idling(34, 85);
		run_random(160);
		wait_quiet();

		write_capacity(5'd3);
		set_idling(85, 34);
		run_random(120);
		wait_quiet();

		// no idling; long output hold-off, then a sender pause
		write_capacity(CAP_RESET);
		set_idling(0, 0);
		run_random(100);
		hold_reqs <= hold_reqs + 1;
		run_random(60);
		wait_quiet();
		run_random(40);
		wait_quiet();

		write_capacity(5'd1);
		run_random(40);
		wait_quiet();

		write_capacity(5'd7);
		run_random(40);
		wait_quiet();

		$display("Sent %0d command words over %0d capacity settings; %0d results checked.",
			words_sent, cap_writes + 1, results);
		$display("Rejected pushes on a full deque: %0d, rejected pops on an empty one: %0d.",
			full_rejects, empty_rejects);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, pending);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
